// ===== src/qhs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qhs_pkg: shared types for the Hoare-partition quicksort block
// Beat types for the load and result sides, plus the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package qhs_pkg;

  localparam int unsigned ValueWidth = 32;

  // Input beat: one element of the set.
  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         is_last;
  } in_item_t;

  // Result beat: one element in ascending order.
  typedef struct packed {
    logic signed [ValueWidth-1:0] sorted_value;
    logic                         last_out;
    logic                         overflow;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // store the input beat or flag overflow
    logic push_init;   // push the full range
    logic pop;         // drop the top of the range stack
    logic take_range;  // latch lo/hi from the popped entry, i = lo, j = hi
    logic take_pivot;  // latch pivot from element read at i
    logic inc_i;
    logic dec_j;
    logic swap_i;      // write store[i] with old store[j]
    logic swap_j;      // write store[j] with old store[i]
    logic push_hi;     // push (j + 1, hi)
    logic push_lo;     // push (lo, j)
    logic clr_k;       // restart the output index
    logic finish;      // clear count, stack and overflow for the next set
  } qhs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic n_lt2;
    logic sp_zero;
    logic stk_lo_ge_hi;
    logic i_scan;
    logic j_scan;
    logic i_ge_j;
    logic hi_ok;
    logic lo_ok;
    logic k_last;
  } qhs_status_t;

endpackage : qhs_pkg
`default_nettype wire

// ===== src/qhs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qhs_datapath: element store, range stack and partition registers
// Executes controller commands; reads of both memories are registered.
// ----------------------------------------------------------------------------
module qhs_datapath import qhs_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire in_item_t    in_item_i,
  input  wire qhs_cmd_t    cmd_i,
  output qhs_status_t      status_o,
  output out_item_t        res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = AW + 1;

  typedef struct packed {
    logic [AW-1:0] hi;
    logic [AW-1:0] lo;
  } range_t;

  logic signed [ValueWidth-1:0] store_mem [DEPTH];
  range_t                       stack_mem [DEPTH];

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] sp_q, sp_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d;
  logic signed [ValueWidth-1:0] piv_q, piv_d;
  logic signed [ValueWidth-1:0] rd_a_q, rd_b_q;
  range_t        rd_stk_q;

  logic                         st_we;
  logic [AW-1:0]                st_addr;
  logic signed [ValueWidth-1:0] st_wdata;
  logic                         sk_we;
  range_t                       sk_wdata;
  logic [AW-1:0]                sk_raddr;
  logic                         room;
  logic [CW-1:0]                cnt_m1;

  assign room     = (cnt_q < CW'(DEPTH));
  assign cnt_m1   = cnt_q - CW'(1);
  assign sk_raddr = AW'(sp_q - CW'(1));

  // Store write port: load, or one half of a swap.
  always_comb begin
    st_we    = 1'b0;
    st_addr  = i_q;
    st_wdata = rd_b_q;
    priority if (cmd_i.load && room) begin
      st_we    = 1'b1;
      st_addr  = cnt_q[AW-1:0];
      st_wdata = in_item_i.value;
    end else if (cmd_i.swap_i) begin
      st_we    = 1'b1;
      st_addr  = i_q;
      st_wdata = rd_b_q;
    end else if (cmd_i.swap_j) begin
      st_we    = 1'b1;
      st_addr  = j_q;
      st_wdata = rd_a_q;
    end
  end

  // Stack write port.
  always_comb begin
    sk_we    = cmd_i.push_init | cmd_i.push_hi | cmd_i.push_lo;
    sk_wdata = '{hi: AW'(cnt_m1), lo: '0};
    priority if (cmd_i.push_hi) begin
      sk_wdata = '{hi: hi_q, lo: j_q + AW'(1)};
    end else if (cmd_i.push_lo) begin
      sk_wdata = '{hi: j_q, lo: lo_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_addr] <= st_wdata;
    end
    if (sk_we) begin
      stack_mem[sp_q[AW-1:0]] <= sk_wdata;
    end
    rd_a_q   <= store_mem[i_q];
    rd_b_q   <= store_mem[j_q];
    rd_stk_q <= stack_mem[sk_raddr];
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    sp_d  = sp_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    i_d   = i_q;
    j_d   = j_q;
    piv_d = piv_q;
    if (cmd_i.load) begin
      if (room) begin
        cnt_d = cnt_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (sk_we) begin
      sp_d = sp_q + CW'(1);
    end
    if (cmd_i.pop) begin
      sp_d = sp_q - CW'(1);
    end
    if (cmd_i.take_range) begin
      lo_d = rd_stk_q.lo;
      hi_d = rd_stk_q.hi;
      i_d  = rd_stk_q.lo;
      j_d  = rd_stk_q.hi;
    end
    if (cmd_i.take_pivot) begin
      piv_d = rd_a_q;
    end
    if (cmd_i.inc_i) begin
      i_d = i_q + AW'(1);
    end
    if (cmd_i.dec_j) begin
      j_d = j_q - AW'(1);
    end
    if (cmd_i.clr_k) begin
      i_d = '0;
    end
    if (cmd_i.finish) begin
      cnt_d = '0;
      ovf_d = 1'b0;
      sp_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      sp_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      sp_q  <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    i_q   <= i_d;
    j_q   <= j_d;
    piv_q <= piv_d;
  end

  assign status_o.n_lt2        = (cnt_q < CW'(2));
  assign status_o.sp_zero      = (sp_q == '0);
  assign status_o.stk_lo_ge_hi = (rd_stk_q.lo >= rd_stk_q.hi);
  assign status_o.i_scan       = (i_q < hi_q) && (rd_a_q < piv_q);
  assign status_o.j_scan       = (j_q > lo_q) && (piv_q < rd_b_q);
  assign status_o.i_ge_j       = (i_q >= j_q);
  assign status_o.hi_ok        = ((KW'(j_q) + KW'(1)) < KW'(hi_q));
  assign status_o.lo_ok        = (lo_q < j_q);
  assign status_o.k_last       = ((KW'(i_q) + KW'(1)) == KW'(cnt_q));

  assign res_o.sorted_value = rd_a_q;
  assign res_o.last_out     = status_o.k_last;
  assign res_o.overflow     = ovf_q;

endmodule : qhs_datapath
`default_nettype wire

// ===== src/qhs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qhs_ctrl: sequencer for load, partition and readout
// Walks the range stack, runs the two Hoare scans and paces result beats.
// ----------------------------------------------------------------------------
module qhs_ctrl import qhs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic        is_last_i,
  input  wire qhs_status_t status_i,
  output qhs_cmd_t         cmd_o,
  output logic             busy_o,
  output logic             strobe_o
);

  localparam logic [4:0] StIdle    = 5'd0;
  localparam logic [4:0] StInit    = 5'd1;
  localparam logic [4:0] StPop     = 5'd2;
  localparam logic [4:0] StRange   = 5'd3;
  localparam logic [4:0] StPivWait = 5'd4;
  localparam logic [4:0] StPiv     = 5'd5;
  localparam logic [4:0] StScanI   = 5'd6;
  localparam logic [4:0] StChkI    = 5'd7;
  localparam logic [4:0] StScanJ   = 5'd8;
  localparam logic [4:0] StChkJ    = 5'd9;
  localparam logic [4:0] StCheck   = 5'd10;
  localparam logic [4:0] StSwapI   = 5'd11;
  localparam logic [4:0] StSwapJ   = 5'd12;
  localparam logic [4:0] StPushHi  = 5'd13;
  localparam logic [4:0] StPushLo  = 5'd14;
  localparam logic [4:0] StOutWait = 5'd15;
  localparam logic [4:0] StOutEmit = 5'd16;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    strobe_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept_i) begin
          cmd_o.load = 1'b1;
          if (is_last_i) begin
            state_d = StInit;
          end
        end
      end
      StInit: begin
        if (status_i.n_lt2) begin
          cmd_o.clr_k = 1'b1;
          state_d     = StOutWait;
        end else begin
          cmd_o.push_init = 1'b1;
          state_d         = StPop;
        end
      end
      StPop: begin
        if (status_i.sp_zero) begin
          cmd_o.clr_k = 1'b1;
          state_d     = StOutWait;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = StRange;
        end
      end
      StRange: begin
        if (status_i.stk_lo_ge_hi) begin
          state_d = StPop;
        end else begin
          cmd_o.take_range = 1'b1;
          state_d          = StPivWait;
        end
      end
      StPivWait: state_d = StPiv;
      StPiv: begin
        cmd_o.take_pivot = 1'b1;
        state_d          = StScanI;
      end
      StScanI: state_d = StChkI;
      StChkI: begin
        if (status_i.i_scan) begin
          cmd_o.inc_i = 1'b1;
          state_d     = StScanI;
        end else begin
          state_d = StScanJ;
        end
      end
      StScanJ: state_d = StChkJ;
      StChkJ: begin
        if (status_i.j_scan) begin
          cmd_o.dec_j = 1'b1;
          state_d     = StScanJ;
        end else begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        state_d = status_i.i_ge_j ? StPushHi : StSwapI;
      end
      StSwapI: begin
        cmd_o.swap_i = 1'b1;
        state_d      = StSwapJ;
      end
      StSwapJ: begin
        cmd_o.swap_j = 1'b1;
        cmd_o.inc_i  = 1'b1;
        cmd_o.dec_j  = 1'b1;
        state_d      = StScanI;
      end
      StPushHi: begin
        cmd_o.push_hi = status_i.hi_ok;
        state_d       = StPushLo;
      end
      StPushLo: begin
        cmd_o.push_lo = status_i.lo_ok;
        state_d       = StPop;
      end
      StOutWait: state_d = StOutEmit;
      StOutEmit: begin
        strobe_o = 1'b1;
        if (status_i.k_last) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end else begin
          cmd_o.inc_i = 1'b1;
          state_d     = StOutWait;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule : qhs_ctrl
`default_nettype wire

// ===== src/quicksort_hoare_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Operation: busy stays low while a set is loading. The beat flagged is_last starts
// the sort, which partitions each range from the stack with scan steps and swaps.
// Readout gives one result beat per stored element; busy drops after the last.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset (rst_ni low, asynchronous) returns to idle with an empty set and stack.
// ----------------------------------------------------------------------------
// quicksort_hoare_sorter: in-place Hoare-partition quicksort
// Loads up to DEPTH signed values, sorts them with an explicit range stack,
// then plays them out in ascending order.
// ----------------------------------------------------------------------------
module quicksort_hoare_sorter import qhs_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire in_item_t in_item_i,
  output logic          busy,
  output logic          res_strobe_o,
  output out_item_t     res_o
);

  qhs_cmd_t    cmd;
  qhs_status_t status;
  logic        accept;

  // Take a load beat only when the sequencer is parked in idle.
  assign accept = start & ~busy;

  // Sequencer: owns the state and paces every memory access.
  qhs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .is_last_i (in_item_i.is_last),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy),
    .strobe_o  (res_strobe_o)
  );

  // Datapath: element store, range stack, scan indices and pivot.
  qhs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .res_o     (res_o)
  );

endmodule : quicksort_hoare_sorter
`default_nettype wire

// ===== src/qhs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qhs_checker: port-level checks on the quicksort sorter
// Watches load beats, busy and the result strobe over time.
// ----------------------------------------------------------------------------
module qhs_checker import qhs_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start,
  input wire in_item_t  in_item_i,
  input wire logic      busy,
  input wire logic      res_strobe_o,
  input wire out_item_t res_o
);

  // Results only appear while the block is sorting or reading out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> busy)
    else $error("result beat while idle");

  // Result beats never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o)
    else $error("back-to-back result beats");

  // The final result beat releases the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.last_out) |=> !busy)
    else $error("busy held after the final result");

  // A closing load beat starts the sort.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_item_i.is_last) |=> busy)
    else $error("sort did not start");

  // A plain load beat leaves the block ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !in_item_i.is_last) |=> !busy)
    else $error("busy after a load beat");

endmodule : qhs_checker

bind quicksort_hoare_sorter qhs_checker u_qhs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .in_item_i    (in_item_i),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);
`default_nettype wire

// ===== test/quicksort_hoare_sorter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_hoare_sorter_tb: self-checking bench for the quicksort block
// Loads sets of signed values through the start/busy command port and checks
// every strobed result against an ascending copy of the set that the bench
// keeps itself. The set is capped at DEPTH, and the overflow flag and the last
// marker are checked on every beat. Covers directed corner sets, then random
// sets with sender idle phases.
// ----------------------------------------------------------------------------
module quicksort_hoare_sorter_tb import qhs_pkg::*;;

  localparam int unsigned Depth     = 64;
  localparam int unsigned ClkPeriod = 10;
  localparam int unsigned PhaseBeats = 80;
  localparam logic signed [ValueWidth-1:0] MinValue = 32'sh8000_0000;
  localparam logic signed [ValueWidth-1:0] MaxValue = 32'sh7FFF_FFFF;

  // Ascending model of the set being loaded, plus the result beats still due.
  class sort_scoreboard;
    logic signed [ValueWidth-1:0] sorted_so_far[$];
    out_item_t                    due_results[$];
    bit                           dropped_seen;
    int unsigned                  mismatches;
    int unsigned                  capacity;

    function new(int unsigned capacity_i);
      capacity     = capacity_i;
      dropped_seen = 1'b0;
      mismatches   = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    // Note one accepted load beat; a beat flagged last queues the whole set.
    function void load_beat(in_item_t beat);
      int        pos;
      out_item_t res;
      if (sorted_so_far.size() < capacity) begin
        // keep the set ordered as it grows, so the readout is a plain walk
        pos = 0;
        while (pos < sorted_so_far.size() && sorted_so_far[pos] <= beat.value) pos++;
        sorted_so_far.insert(pos, beat.value);
      end else begin
        dropped_seen = 1'b1;
      end
      if (!beat.is_last) return;
      for (int k = 0; k < sorted_so_far.size(); k++) begin
        res.sorted_value = sorted_so_far[k];
        res.last_out     = (k == sorted_so_far.size() - 1);
        res.overflow     = dropped_seen;
        due_results.push_back(res);
      end
      sorted_so_far.delete();
      dropped_seen = 1'b0;
    endfunction

    function void check_beat(out_item_t got);
      out_item_t exp;
      if (due_results.size() == 0) begin
        report($sformatf("result beat with nothing due: value %0d last %0b ovf %0b",
                         got.sorted_value, got.last_out, got.overflow));
        return;
      end
      exp = due_results.pop_front();
      if (got.sorted_value !== exp.sorted_value || got.last_out !== exp.last_out ||
          got.overflow !== exp.overflow)
        report($sformatf("expected value %0d last %0b ovf %0b, got value %0d last %0b ovf %0b",
                         exp.sorted_value, exp.last_out, exp.overflow,
                         got.sorted_value, got.last_out, got.overflow));
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function bit clean();
      if (due_results.size() != 0)
        report($sformatf("%0d result beats never arrived", due_results.size()));
      return mismatches == 0;
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item_i = '0;
  logic      busy;
  logic      res_strobe_o;
  out_item_t res_o;

  sort_scoreboard sb = new(Depth);
  int unsigned    idle_pct = 0;
  int unsigned    beats_sent = 0;
  int unsigned    sets_sent = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  quicksort_hoare_sorter #(
    .DEPTH(Depth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .in_item_i   (in_item_i),
    .busy        (busy),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  // Results cannot be held off: take every strobed beat at the edge ending it.
  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) sb.check_beat(res_o);
  end

  // Mix of full-range words, a narrow band that forces duplicates, and extremes.
  function automatic logic signed [ValueWidth-1:0] random_value();
    case ($urandom_range(4))
      3: return $urandom_range(6) - 3;
      4: begin
        case ($urandom_range(3))
          0: return MinValue;
          1: return MaxValue;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Drive one load beat, hold it until accepted, then idle at random.
  task automatic send_beat(logic signed [ValueWidth-1:0] v, bit last);
    in_item_t beat;
    beat.value   = v;
    beat.is_last = last;
    start     <= 1'b1;
    in_item_i <= beat;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.load_beat(beat);
    beats_sent++;
    // drop start and put junk on the payload while idle
    while ($urandom_range(99) < idle_pct) begin
      start     <= 1'b0;
      in_item_i <= {$urandom, 1'($urandom)};
      @(posedge clk_i);
    end
  endtask

  // Arithmetic run: already sorted, reversed, or all equal depending on step.
  task automatic send_ramp(logic signed [ValueWidth-1:0] base,
                           logic signed [ValueWidth-1:0] step, int unsigned size);
    for (int unsigned i = 0; i < size; i++) send_beat(base + i * step, i == size - 1);
  endtask

  task automatic send_set(int unsigned size);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      send_ramp(random_value(), $urandom_range(3), size);
    end else if (pick == 1) begin
      send_ramp(random_value(), -$urandom_range(3), size);
    end else begin
      for (int unsigned i = 0; i < size; i++) send_beat(random_value(), i == size - 1);
    end
    sets_sent++;
  endtask

  // Hold the sender off until every due result has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic signed [ValueWidth-1:0] corner[8];
    int unsigned                  idle_plan[4];
    int unsigned                  phase_start;
    int unsigned                  size;
    int unsigned                  roll;
    corner    = '{0, -1, MaxValue, MinValue, 1, MinValue, MaxValue, 0};
    // the receiver cannot stall, so its phase runs with no sender idling
    idle_plan = '{0, 51, 0, 6};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single element, a pair, extremes with duplicates,
    // sorted and reversed runs, and an all-equal set.
    send_beat(MaxValue, 1'b1);
    send_beat(MaxValue, 1'b0);
    send_beat(MinValue, 1'b1);
    for (int i = 0; i < 8; i++) send_beat(corner[i], i == 7);
    send_ramp(-2, 1, 5);
    send_ramp(MaxValue, -3, 5);
    send_ramp(7, 0, 4);
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct    = idle_plan[p];
      phase_start = beats_sent;
      while (beats_sent - phase_start < PhaseBeats) begin
        roll = $urandom_range(99);
        // one overflowing set and one exactly full set are always included
        if (sets_sent == 0 || roll < 3)
          size = Depth + 1 + $urandom_range(2);
        else if (sets_sent == 5 || roll < 6)
          size = Depth;
        else if (roll < 12)
          size = $urandom_range(Depth - 1, 2);
        else
          size = $urandom_range(12, 1);
        send_set(size);
      end
      drain();
    end

    // let stray result beats show up before the final check
    repeat (50) @(posedge clk_i);
    if (sb.clean())
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[%0t] timeout with %0d result beats still due", $time, sb.pending());
    $display("Regression FAIL");
    $finish;
  end

endmodule
